[src/greedy_column_cell_placer_assert.svh]
// Assertion macros for the greedy column cell placer.
// Included by the top level; needs nothing else.
`ifndef GREEDY_COLUMN_CELL_PLACER_ASSERT_SVH
`define GREEDY_COLUMN_CELL_PLACER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GCCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GCCP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gccp_pkg.sv]
// Shared constants, register indexes and types of the greedy column cell placer.
// Used by the remainder divider and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gccp_pkg;

  // Coordinate range that bounds the row region.
  localparam int unsigned COORD_BITS = 24;

  // Field widths.
  localparam int unsigned DIM_W   = 24;  // cell width and height, die bounds
  localparam int unsigned POS_W   = 25;  // stack top, right edge, doubled centers
  localparam int unsigned AREA_W  = 48;  // areas
  localparam int unsigned RCNT_W  = 16;  // row count
  localparam int unsigned BOUND_W = DIM_W + RCNT_W;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;

  // Standard cell top bound never exceeds the coordinate range.
  localparam logic [BOUND_W-1:0] ROW_BOUND_CAP =
    BOUND_W'((64'd1 << COORD_BITS) - 64'd1);

  // Register indexes (byte address is eight times the index).
  localparam logic [REG_IDX_W-1:0] REG_DIE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_BASE_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AREA_LIMIT = 3'd5;

  // Status of the iterative remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[src/gccp_rem_div.sv]
// Radix-2 restoring divider that returns the remainder, one quotient bit per cycle.
// Depends on gccp_pkg for its default widths and status type.
`timescale 1ns / 1ps
`default_nettype none

module gccp_rem_div #(
  parameter int unsigned DVD_W = gccp_pkg::POS_W,
  parameter int unsigned DVS_W = gccp_pkg::DIM_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [DVD_W-1:0]         dividend_i,
  input  wire logic [DVS_W-1:0]         divisor_i,
  output gccp_pkg::div_stat_t           stat_o,
  output logic      [DVS_W-1:0]         rem_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One trial subtraction per cycle; the partial remainder stays below the divisor.
  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Iteration control resets; the operands are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

[src/greedy_column_cell_placer.sv]
// Top level of the greedy column cell placer: sequencer, shared multiplier and pass state.
// Depends on gccp_pkg, gccp_rem_div and greedy_column_cell_placer_assert.svh.
//
// Usage:
// Cells arrive on the s_axis channel sorted by decreasing width, one beat per cell;
// s_axis_tuser[0] starts a new pass and s_axis_tuser[1] marks a macro. Every input
// beat yields exactly one m_axis beat with the placed flag and the doubled center.
// Each accepted cell passes through the area multiply, the row bound multiply and
// the evaluate step; a standard cell above the first row also passes through the
// 25-step remainder divider that snaps the stack top to a row boundary before it is
// evaluated. A new beat is taken only once the sequencer is back in idle, after the
// previous result is written into the output register.
// One 24x24 multiplier is shared by the cell area and the row region height.
// When the receiver stalls, the result waits in the output register; the next cell
// is still accepted and worked on, and its result is held back until the register
// empties. Reset clears the pass state and sets the registers to their defaults:
// full die, one row of height one at y zero, no area limit. The APB port is to be written
// only while no cell is in flight; the block does not enforce this. pready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_column_cell_placer_assert.svh"

module greedy_column_cell_placer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input cells.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [47:0]                         s_axis_tdata,  // cell_width, cell_height
  input  wire logic [1:0]                          s_axis_tuser,  // first_of_pass, is_macro
  // Placement results.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [55:0]                              m_axis_tdata,  // center_x_twice, center_y_twice, zero fill
  output logic [0:0]                               m_axis_tuser,  // placed
  // Register port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [gccp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [gccp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [gccp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int unsigned DIM_W   = gccp_pkg::DIM_W;
  localparam int unsigned POS_W   = gccp_pkg::POS_W;
  localparam int unsigned AREA_W  = gccp_pkg::AREA_W;
  localparam int unsigned RCNT_W  = gccp_pkg::RCNT_W;
  localparam int unsigned BOUND_W = gccp_pkg::BOUND_W;
  localparam int unsigned TY_W    = POS_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AREA,
    ST_MUL_ROW,
    ST_DIV,
    ST_EVAL
  } state_e;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [DIM_W-1:0]  die_width_q, die_height_q, row_height_q, row_base_q;
  logic [RCNT_W-1:0] row_count_q;
  logic [AREA_W-1:0] area_limit_q;
  logic [gccp_pkg::REG_IDX_W-1:0] reg_idx;
  logic              reg_wr;

  assign reg_idx = paddr[gccp_pkg::CFG_ADDR_W-1:3];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      die_width_q  <= '1;
      die_height_q <= '1;
      row_height_q <= DIM_W'(1);
      row_count_q  <= RCNT_W'(1);
      row_base_q   <= '0;
      area_limit_q <= '1;
    end else if (reg_wr) begin
      case (reg_idx)
        gccp_pkg::REG_DIE_WIDTH:  die_width_q  <= pwdata[DIM_W-1:0];
        gccp_pkg::REG_DIE_HEIGHT: die_height_q <= pwdata[DIM_W-1:0];
        gccp_pkg::REG_ROW_HEIGHT: row_height_q <= pwdata[DIM_W-1:0];
        gccp_pkg::REG_ROW_COUNT:  row_count_q  <= pwdata[RCNT_W-1:0];
        gccp_pkg::REG_ROW_BASE_Y: row_base_q   <= pwdata[DIM_W-1:0];
        gccp_pkg::REG_AREA_LIMIT: area_limit_q <= pwdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      gccp_pkg::REG_DIE_WIDTH:  prdata = gccp_pkg::CFG_DATA_W'(die_width_q);
      gccp_pkg::REG_DIE_HEIGHT: prdata = gccp_pkg::CFG_DATA_W'(die_height_q);
      gccp_pkg::REG_ROW_HEIGHT: prdata = gccp_pkg::CFG_DATA_W'(row_height_q);
      gccp_pkg::REG_ROW_COUNT:  prdata = gccp_pkg::CFG_DATA_W'(row_count_q);
      gccp_pkg::REG_ROW_BASE_Y: prdata = gccp_pkg::CFG_DATA_W'(row_base_q);
      gccp_pkg::REG_AREA_LIMIT: prdata = gccp_pkg::CFG_DATA_W'(area_limit_q);
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer, pass state and output register
  // ------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [DIM_W-1:0]   column_left_q, column_left_d;
  logic [POS_W-1:0]   stack_top_q, stack_top_d;
  logic [POS_W-1:0]   right_edge_q, right_edge_d;
  logic [AREA_W-1:0]  used_area_q, used_area_d;
  logic [DIM_W-1:0]   cw_q, cw_d, ch_q, ch_d;
  logic               macro_q, macro_d;
  logic [AREA_W-1:0]  area_q, area_d;
  logic [BOUND_W-1:0] bound_q, bound_d;
  logic [TY_W-1:0]    ty_q, ty_d;
  logic               m_valid_q, m_valid_d;
  logic               m_placed_q, m_placed_d;
  logic [POS_W-1:0]   m_cx_q, m_cx_d, m_cy_q, m_cy_d;

  // Shared multiplier: cell area first, then the row region height.
  logic [DIM_W-1:0]   rh_eff;
  logic [DIM_W-1:0]   mul_a, mul_b;
  logic [AREA_W-1:0]  mul_p;
  logic [BOUND_W-1:0] row_bound;

  assign rh_eff = (row_height_q == '0) ? DIM_W'(1) : row_height_q;
  assign mul_a  = (state_q == ST_MUL_AREA) ? cw_q : DIM_W'(row_count_q);
  assign mul_b  = (state_q == ST_MUL_AREA) ? ch_q : rh_eff;
  assign mul_p  = mul_a * mul_b;
  assign row_bound = (mul_p[BOUND_W-1:0] > gccp_pkg::ROW_BOUND_CAP) ?
                     gccp_pkg::ROW_BOUND_CAP : mul_p[BOUND_W-1:0];

  // Distance above the first row, whose remainder by the row height gives the snap.
  logic                above_base;
  logic [POS_W-1:0]    base_gap;
  logic                div_start;
  gccp_pkg::div_stat_t div_stat;
  logic [DIM_W-1:0]    div_rem;
  logic [TY_W-1:0]     snap_add;

  assign above_base = stack_top_q > POS_W'(row_base_q);
  assign base_gap   = above_base ? (stack_top_q - POS_W'(row_base_q)) : '0;
  assign div_start  = (state_q == ST_MUL_ROW) && !macro_q && above_base;
  assign snap_add   = (div_rem == '0) ? '0 : TY_W'(rh_eff - div_rem);

  gccp_rem_div #(
    .DVD_W (POS_W),
    .DVS_W (DIM_W)
  ) u_rem_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_gap),
    .divisor_i  (rh_eff),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // Placement decision for the current cell.
  logic [AREA_W:0]    area_sum;
  logic               area_ok;
  logic [TY_W:0]      ty_top;
  logic               fit_v;
  logic               fit_cur;
  logic [TY_W-1:0]    re_end;
  logic               fit_re;
  logic [DIM_W-1:0]   new_y;
  logic [POS_W-1:0]   new_top;
  logic               fit_new;
  logic               place_cur, place_new, placed;
  logic [POS_W-1:0]   tx;
  logic [TY_W-1:0]    ty_sel;
  logic [TY_W-1:0]    tx_end;
  logic [TY_W:0]      ty_end;
  logic [TY_W-1:0]    cx_full;
  logic [TY_W:0]      cy_full;
  logic               out_free;

  assign area_sum  = {1'b0, used_area_q} + {1'b0, area_q};
  assign area_ok   = area_sum <= {1'b0, area_limit_q};
  assign ty_top    = {1'b0, ty_q} + (TY_W + 1)'(ch_q);
  assign fit_v     = BOUND_W'(ty_top) <= bound_q;
  assign fit_cur   = ({1'b0, column_left_q} + {1'b0, cw_q}) <= {1'b0, die_width_q};
  assign re_end    = {1'b0, right_edge_q} + TY_W'(cw_q);
  assign fit_re    = re_end <= TY_W'(die_width_q);
  assign new_y     = macro_q ? '0 : row_base_q;
  assign new_top   = {1'b0, new_y} + {1'b0, ch_q};
  assign fit_new   = BOUND_W'(new_top) <= bound_q;
  assign place_cur = area_ok && fit_v && fit_cur;
  assign place_new = area_ok && !fit_v && fit_re && fit_new;
  assign placed    = place_cur || place_new;
  assign tx        = place_cur ? {1'b0, column_left_q} : right_edge_q;
  assign ty_sel    = place_cur ? ty_q : TY_W'(new_y);
  assign tx_end    = {1'b0, tx} + TY_W'(cw_q);
  assign ty_end    = {1'b0, ty_sel} + (TY_W + 1)'(ch_q);
  assign cx_full   = {tx, 1'b0} + TY_W'(cw_q);
  assign cy_full   = {ty_sel, 1'b0} + (TY_W + 1)'(ch_q);
  assign out_free  = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    column_left_d = column_left_q;
    stack_top_d   = stack_top_q;
    right_edge_d  = right_edge_q;
    used_area_d   = used_area_q;
    cw_d          = cw_q;
    ch_d          = ch_q;
    macro_d       = macro_q;
    area_d        = area_q;
    bound_d       = bound_q;
    ty_d          = ty_q;
    m_valid_d     = m_valid_q;
    m_placed_d    = m_placed_q;
    m_cx_d        = m_cx_q;
    m_cy_d        = m_cy_q;

    // The output beat leaves when the receiver takes it.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cw_d    = s_axis_tdata[DIM_W-1:0];
          ch_d    = s_axis_tdata[2*DIM_W-1:DIM_W];
          macro_d = s_axis_tuser[1];
          if (s_axis_tuser[0]) begin
            column_left_d = '0;
            stack_top_d   = '0;
            right_edge_d  = '0;
            used_area_d   = '0;
          end
          state_d = ST_MUL_AREA;
        end
      end
      ST_MUL_AREA: begin
        area_d  = mul_p;
        state_d = ST_MUL_ROW;
      end
      ST_MUL_ROW: begin
        bound_d = macro_q ? BOUND_W'(die_height_q) : row_bound;
        if (div_start) begin
          state_d = ST_DIV;
        end else begin
          ty_d    = macro_q ? TY_W'(stack_top_q) : TY_W'(row_base_q);
          state_d = ST_EVAL;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ty_d    = TY_W'(stack_top_q) + snap_add;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_placed_d = placed;
          m_cx_d     = placed ? cx_full[POS_W-1:0] : '0;
          m_cy_d     = placed ? cy_full[POS_W-1:0] : '0;
          if (placed) begin
            column_left_d = tx[DIM_W-1:0];
            stack_top_d   = ty_end[POS_W-1:0];
            if (tx_end > TY_W'(right_edge_q)) begin
              right_edge_d = tx_end[POS_W-1:0];
            end
            used_area_d = area_sum[AREA_W-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, pass state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      column_left_q <= '0;
      stack_top_q   <= '0;
      right_edge_q  <= '0;
      used_area_q   <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      column_left_q <= column_left_d;
      stack_top_q   <= stack_top_d;
      right_edge_q  <= right_edge_d;
      used_area_q   <= used_area_d;
      m_valid_q     <= m_valid_d;
    end
  end

  // Cell operands, intermediate results and output payload.
  always_ff @(posedge clk_i) begin
    cw_q       <= cw_d;
    ch_q       <= ch_d;
    macro_q    <= macro_d;
    area_q     <= area_d;
    bound_q    <= bound_d;
    ty_q       <= ty_d;
    m_placed_q <= m_placed_d;
    m_cx_q     <= m_cx_d;
    m_cy_q     <= m_cy_d;
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tuser[0] = m_placed_q;
  assign m_axis_tdata    = {6'b0, m_cy_q, m_cx_q};

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `GCCP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted again while a cell is in work")
  `GCCP_ASSERT_IMP(a_skip_is_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "skipped cell carries nonzero center")
  `GCCP_ASSERT_IMP(a_column_in_edge, clk_i, rst_ni, 1'b1, right_edge_q >= {1'b0, column_left_q}, "column starts right of the rightmost edge")
  `GCCP_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, div_stat.done, state_q == ST_DIV, "divider finished outside the snap step")

endmodule

`default_nettype wire
